FILE: rtl/trr_pkg.sv
// Shared constants, types and helpers of the two-level round-robin scheduler.
package trr_pkg;

  localparam int MAX_TASKS   = 8;
  localparam int MAX_THREADS = 4;
  localparam int NTH         = MAX_TASKS * MAX_THREADS;
  localparam int TASK_W      = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int THR_W       = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int TH_AW       = (NTH > 1) ? $clog2(NTH) : 1;
  localparam int PID_W       = 3;
  localparam int ID_W        = 8;
  localparam int CFG_IW      = 1;
  localparam logic [7:0] SLICE_RESET = 8'd10;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_SPAWN = 3'd1,
    KIND_ADD   = 3'd2,
    KIND_FIN   = 3'd3,
    KIND_KILL  = 3'd4
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_ENABLE = 1'b0,
    CFG_SLICE  = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_WAIT,
    ST_TICK_START,
    ST_CLN_TASK,
    ST_CLN_RD,
    ST_CLN_WR,
    ST_CLN_FIN,
    ST_CLN_ORD,
    ST_TICK_RUN,
    ST_TICK_DEC,
    ST_ADV,
    ST_RESP_RD,
    ST_OUT
  } state_t;

  function automatic logic [TH_AW-1:0] th_addr(input logic [TASK_W-1:0] s,
                                               input logic [THR_W-1:0] p);
    th_addr = TH_AW'(TH_AW'(s) * TH_AW'(MAX_THREADS) + TH_AW'(p));
  endfunction

endpackage

FILE: rtl/trr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module trr_ram #(
  parameter int DW    = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/two_level_round_robin_scheduler.sv
// Top level of the two-level round-robin scheduler: sequencer, task tables, thread RAMs.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | kind, target_pid
//   out_    | output    | out_valid/out_stall | status, new_id, running_*
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat at a time; a spawn, refusal or thread finish goes from dispatch to the
// ident read and output states, add thread also waits on an ident read, and a plain
// tick runs its start and run states, a decrement while a thread runs, and a walk of the
// task order when a task ends its turn. A tick with cleanup pending adds two passes over
// the task order: compaction marks a task dead whose main thread died, else rereads and
// rewrites each surviving thread, set by the RAM read latency; the order pass follows.
// Reset is synchronous; the thread RAMs need no clearing pass.
// A stalled result holds in the output register while the next beat is taken.
module two_level_round_robin_scheduler
  import trr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_kind,
  input  logic [2:0]        in_target_pid,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [7:0]        out_new_id,
  output logic              out_running_valid,
  output logic [2:0]        out_running_pid,
  output logic              out_running_parent_valid,
  output logic [2:0]        out_running_parent_pid,
  output logic [7:0]        out_running_thread_id,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [7:0]        cfg_data
);

  state_t state_r, state_nxt;

  logic                 enabled_r;
  logic [7:0]           slice_r;
  logic [2:0]           kind_r, kind_nxt;
  logic [PID_W-1:0]     tgt_r, tgt_nxt;

  logic [MAX_TASKS-1:0] task_valid_r, task_valid_nxt;
  logic [MAX_TASKS-1:0] task_dead_r, task_dead_nxt;
  logic [MAX_TASKS-1:0] task_curv_r, task_curv_nxt;
  logic [PID_W-1:0]     task_pid_r [MAX_TASKS];
  logic [PID_W-1:0]     task_pid_nxt [MAX_TASKS];
  logic [MAX_TASKS-1:0] task_hp_r, task_hp_nxt;
  logic [PID_W-1:0]     task_par_r [MAX_TASKS];
  logic [PID_W-1:0]     task_par_nxt [MAX_TASKS];
  logic [THR_W-1:0]     task_cur_r [MAX_TASKS];
  logic [THR_W-1:0]     task_cur_nxt [MAX_TASKS];
  logic [TASK_W-1:0]    order_r [MAX_TASKS];
  logic [TASK_W-1:0]    order_nxt [MAX_TASKS];
  logic [TASK_W:0]      count_r, count_nxt;
  logic [NTH-1:0]       thr_valid_r, thr_valid_nxt;
  logic [NTH-1:0]       thr_dead_r, thr_dead_nxt;
  logic                 run_v_r, run_v_nxt;
  logic [TASK_W-1:0]    rs_r, rs_nxt;
  logic                 cleanup_r, cleanup_nxt;

  logic [TASK_W:0]      k_r, k_nxt;
  logic [TASK_W:0]      n_r, n_nxt;
  logic                 adv_r, adv_nxt;
  logic [THR_W:0]       p_r, p_nxt;
  logic [THR_W:0]       kept_r, kept_nxt;
  logic [THR_W:0]       newcur_r, newcur_nxt;
  logic                 lost_r, lost_nxt;
  logic                 status_r, status_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_status_r, out_status_nxt;
  logic [7:0]           out_new_id_r, out_new_id_nxt;
  logic                 out_rv_r, out_rv_nxt;
  logic [2:0]           out_rpid_r, out_rpid_nxt;
  logic                 out_rpv_r, out_rpv_nxt;
  logic [2:0]           out_rppid_r, out_rppid_nxt;
  logic [7:0]           out_rtid_r, out_rtid_nxt;

  logic                 id_we, id_re, tm_we, tm_re;
  logic [TH_AW-1:0]     id_waddr, id_raddr, tm_waddr, tm_raddr;
  logic [7:0]           id_wdata, id_q, tm_wdata, tm_q;

  logic [TASK_W-1:0]    cs;
  logic                 k_end;
  logic [THR_W-1:0]     cur_rs;
  logic [THR_W-1:0]     p_idx;
  logic                 p_end;
  logic                 dead0;
  logic                 free_found;
  logic [TASK_W-1:0]    free_slot;
  logic [PID_W-1:0]     free_pid;
  logic [MAX_TASKS-1:0] pid_used;
  logic                 kill_hit;
  logic [TASK_W-1:0]    kill_slot;
  logic [THR_W:0]       add_n;
  logic                 add_run;
  logic                 add_ok;
  logic [7:0]           dec;
  logic [THR_W:0]       c1;
  logic                 next_ok;
  logic                 out_load;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      slice_r   <= SLICE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ENABLE: enabled_r <= cfg_data[0];
        CFG_SLICE:  slice_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cs      = order_r[k_r[TASK_W-1:0]];
  assign k_end   = (k_r == count_r);
  assign cur_rs  = task_cur_r[rs_r];
  assign p_idx   = p_r[THR_W-1:0];
  assign p_end   = (p_r == (THR_W+1)'(MAX_THREADS)) || !thr_valid_r[th_addr(cs, p_idx)];
  assign dead0   = thr_dead_r[th_addr(cs, '0)];
  assign dec     = tm_q - 8'd1;
  assign c1      = {1'b0, cur_rs} + (THR_W+1)'(1);
  assign next_ok = (c1 < (THR_W+1)'(MAX_THREADS)) &&
                   thr_valid_r[th_addr(rs_r, c1[THR_W-1:0])];
  assign add_ok  = run_v_r && (add_n != '0) && (add_n < (THR_W+1)'(MAX_THREADS));
  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int s = MAX_TASKS - 1; s >= 0; s--) begin
      if (!task_valid_r[s]) begin
        free_found = 1'b1;
        free_slot  = TASK_W'(s);
      end
    end
  end

  always_comb begin
    pid_used = '0;
    for (int s = 0; s < MAX_TASKS; s++) begin
      if (task_valid_r[s]) begin
        pid_used[task_pid_r[s]] = 1'b1;
      end
    end
    free_pid = '0;
    for (int p = MAX_TASKS - 1; p >= 0; p--) begin
      if (!pid_used[p]) begin
        free_pid = PID_W'(p);
      end
    end
  end

  always_comb begin
    kill_hit  = 1'b0;
    kill_slot = '0;
    for (int s = MAX_TASKS - 1; s >= 0; s--) begin
      if (task_valid_r[s] && task_pid_r[s] == tgt_r) begin
        kill_hit  = 1'b1;
        kill_slot = TASK_W'(s);
      end
    end
  end

  always_comb begin
    add_n   = '0;
    add_run = 1'b1;
    for (int p = 0; p < MAX_THREADS; p++) begin
      if (add_run && thr_valid_r[th_addr(rs_r, THR_W'(p))]) begin
        add_n = add_n + (THR_W+1)'(1);
      end else begin
        add_run = 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (kind_r)
          KIND_TICK: state_nxt = ST_TICK_START;
          KIND_ADD:  state_nxt = add_ok ? ST_ADD_WAIT : ST_RESP_RD;
          KIND_KILL: state_nxt = kill_hit ? ST_TICK_START : ST_RESP_RD;
          default:   state_nxt = ST_RESP_RD;
        endcase
      end
      ST_ADD_WAIT: state_nxt = ST_RESP_RD;
      ST_TICK_START: begin
        if (!enabled_r)     state_nxt = ST_RESP_RD;
        else if (cleanup_r) state_nxt = ST_CLN_TASK;
        else                state_nxt = ST_TICK_RUN;
      end
      ST_CLN_TASK: begin
        if (k_end)       state_nxt = ST_CLN_ORD;
        else if (!dead0) state_nxt = ST_CLN_RD;
      end
      ST_CLN_RD: begin
        if (p_end) state_nxt = ST_CLN_FIN;
        else if (!thr_dead_r[th_addr(cs, p_idx)]) state_nxt = ST_CLN_WR;
      end
      ST_CLN_WR:  state_nxt = ST_CLN_RD;
      ST_CLN_FIN: state_nxt = ST_CLN_TASK;
      ST_CLN_ORD: begin
        if (k_end) state_nxt = ST_TICK_RUN;
      end
      ST_TICK_RUN: begin
        state_nxt = (run_v_r && task_curv_r[rs_r]) ? ST_TICK_DEC : ST_RESP_RD;
      end
      ST_TICK_DEC: begin
        state_nxt = (dec == 8'd0 && !next_ok) ? ST_ADV : ST_RESP_RD;
      end
      ST_ADV: begin
        if (k_end || cs == rs_r) state_nxt = ST_RESP_RD;
      end
      ST_RESP_RD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt       = kind_r;
    tgt_nxt        = tgt_r;
    task_valid_nxt = task_valid_r;
    task_dead_nxt  = task_dead_r;
    task_curv_nxt  = task_curv_r;
    task_pid_nxt   = task_pid_r;
    task_hp_nxt    = task_hp_r;
    task_par_nxt   = task_par_r;
    task_cur_nxt   = task_cur_r;
    order_nxt      = order_r;
    count_nxt      = count_r;
    thr_valid_nxt  = thr_valid_r;
    thr_dead_nxt   = thr_dead_r;
    run_v_nxt      = run_v_r;
    rs_nxt         = rs_r;
    cleanup_nxt    = cleanup_r;
    k_nxt          = k_r;
    n_nxt          = n_r;
    adv_nxt        = adv_r;
    p_nxt          = p_r;
    kept_nxt       = kept_r;
    newcur_nxt     = newcur_r;
    lost_nxt       = lost_r;
    status_nxt     = status_r;
    id_nxt         = id_r;
    id_we    = 1'b0;
    id_waddr = '0;
    id_wdata = '0;
    id_re    = 1'b0;
    id_raddr = '0;
    tm_we    = 1'b0;
    tm_waddr = '0;
    tm_wdata = '0;
    tm_re    = 1'b0;
    tm_raddr = '0;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_new_id_nxt = out_new_id_r;
    out_rv_nxt     = out_rv_r;
    out_rpid_nxt   = out_rpid_r;
    out_rpv_nxt    = out_rpv_r;
    out_rppid_nxt  = out_rppid_r;
    out_rtid_nxt   = out_rtid_r;

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        kind_nxt   = in_kind;
        tgt_nxt    = in_target_pid;
        status_nxt = 1'b0;
        id_nxt     = '0;
        k_nxt      = '0;
      end
      ST_DISPATCH: begin
        case (kind_r)
          KIND_TICK: ;
          KIND_SPAWN: begin
            if (!free_found) begin
              status_nxt = 1'b1;
            end else begin
              task_valid_nxt[free_slot] = 1'b1;
              task_pid_nxt[free_slot]   = free_pid;
              task_hp_nxt[free_slot]    = run_v_r;
              task_par_nxt[free_slot]   = run_v_r ? task_pid_r[rs_r] : '0;
              task_dead_nxt[free_slot]  = 1'b0;
              task_curv_nxt[free_slot]  = 1'b0;
              task_cur_nxt[free_slot]   = '0;
              for (int p = 0; p < MAX_THREADS; p++) begin
                thr_valid_nxt[th_addr(free_slot, THR_W'(p))] = 1'b0;
                thr_dead_nxt[th_addr(free_slot, THR_W'(p))]  = 1'b0;
              end
              thr_valid_nxt[th_addr(free_slot, '0)] = 1'b1;
              id_we    = 1'b1;
              id_waddr = th_addr(free_slot, '0);
              id_wdata = '0;
              tm_we    = 1'b1;
              tm_waddr = th_addr(free_slot, '0);
              tm_wdata = slice_r;
              order_nxt[count_r[TASK_W-1:0]] = free_slot;
              count_nxt = count_r + (TASK_W+1)'(1);
              id_nxt    = ID_W'(free_pid);
            end
          end
          KIND_ADD: begin
            if (!add_ok) begin
              status_nxt = 1'b1;
            end else begin
              id_re    = 1'b1;
              id_raddr = th_addr(rs_r, THR_W'(add_n - (THR_W+1)'(1)));
            end
          end
          KIND_FIN: begin
            if (run_v_r && task_curv_r[rs_r]) begin
              thr_dead_nxt[th_addr(rs_r, cur_rs)] = 1'b1;
              cleanup_nxt = 1'b1;
            end else begin
              status_nxt = 1'b1;
            end
          end
          KIND_KILL: begin
            if (kill_hit) begin
              task_dead_nxt[kill_slot] = 1'b1;
              cleanup_nxt = 1'b1;
            end else begin
              status_nxt = 1'b1;
            end
          end
          default: status_nxt = 1'b1;
        endcase
      end
      ST_ADD_WAIT: begin
        if (id_q >= 8'd254) begin
          status_nxt = 1'b1;
        end else begin
          thr_valid_nxt[th_addr(rs_r, add_n[THR_W-1:0])] = 1'b1;
          thr_dead_nxt[th_addr(rs_r, add_n[THR_W-1:0])]  = 1'b0;
          id_we    = 1'b1;
          id_waddr = th_addr(rs_r, add_n[THR_W-1:0]);
          id_wdata = id_q + 8'd1;
          tm_we    = 1'b1;
          tm_waddr = th_addr(rs_r, add_n[THR_W-1:0]);
          tm_wdata = slice_r;
          id_nxt   = id_q + 8'd1;
        end
      end
      ST_CLN_TASK: begin
        if (k_end) begin
          k_nxt   = '0;
          n_nxt   = '0;
          adv_nxt = 1'b0;
        end else if (dead0) begin
          task_dead_nxt[cs] = 1'b1;
          k_nxt = k_r + (TASK_W+1)'(1);
        end else begin
          p_nxt      = '0;
          kept_nxt   = '0;
          newcur_nxt = '0;
          lost_nxt   = 1'b0;
        end
      end
      ST_CLN_RD: begin
        if (!p_end) begin
          if (task_curv_r[cs] && p_idx == task_cur_r[cs]) begin
            newcur_nxt = kept_r;
            lost_nxt   = thr_dead_r[th_addr(cs, p_idx)];
          end
          if (!thr_dead_r[th_addr(cs, p_idx)]) begin
            id_re    = 1'b1;
            id_raddr = th_addr(cs, p_idx);
            tm_re    = 1'b1;
            tm_raddr = th_addr(cs, p_idx);
          end else begin
            p_nxt = p_r + (THR_W+1)'(1);
          end
        end
      end
      ST_CLN_WR: begin
        thr_valid_nxt[th_addr(cs, kept_r[THR_W-1:0])] = 1'b1;
        thr_dead_nxt[th_addr(cs, kept_r[THR_W-1:0])]  = 1'b0;
        id_we    = 1'b1;
        id_waddr = th_addr(cs, kept_r[THR_W-1:0]);
        id_wdata = id_q;
        tm_we    = 1'b1;
        tm_waddr = th_addr(cs, kept_r[THR_W-1:0]);
        tm_wdata = tm_q;
        kept_nxt = kept_r + (THR_W+1)'(1);
        p_nxt    = p_r + (THR_W+1)'(1);
      end
      ST_CLN_FIN: begin
        for (int p = 0; p < MAX_THREADS; p++) begin
          if ((THR_W+1)'(p) >= kept_r) begin
            thr_valid_nxt[th_addr(cs, THR_W'(p))] = 1'b0;
            thr_dead_nxt[th_addr(cs, THR_W'(p))]  = 1'b0;
          end
        end
        if (task_curv_r[cs]) begin
          task_cur_nxt[cs] = (newcur_r >= kept_r) ? '0 : newcur_r[THR_W-1:0];
          if (lost_r) begin
            tm_we    = 1'b1;
            tm_waddr = th_addr(cs, (newcur_r >= kept_r) ? '0 : newcur_r[THR_W-1:0]);
            tm_wdata = slice_r;
          end
        end
        k_nxt = k_r + (TASK_W+1)'(1);
      end
      ST_CLN_ORD: begin
        if (k_end) begin
          if (adv_r) run_v_nxt = 1'b0;
          count_nxt   = n_r;
          cleanup_nxt = 1'b0;
        end else begin
          if (task_dead_r[cs]) begin
            if (run_v_r && rs_r == cs) adv_nxt = 1'b1;
            task_valid_nxt[cs] = 1'b0;
            task_dead_nxt[cs]  = 1'b0;
            task_curv_nxt[cs]  = 1'b0;
            for (int p = 0; p < MAX_THREADS; p++) begin
              thr_valid_nxt[th_addr(cs, THR_W'(p))] = 1'b0;
              thr_dead_nxt[th_addr(cs, THR_W'(p))]  = 1'b0;
            end
          end else begin
            order_nxt[n_r[TASK_W-1:0]] = cs;
            n_nxt = n_r + (TASK_W+1)'(1);
            if (adv_r) begin
              rs_nxt  = cs;
              adv_nxt = 1'b0;
            end
          end
          k_nxt = k_r + (TASK_W+1)'(1);
        end
      end
      ST_TICK_RUN: begin
        if (run_v_r) begin
          if (task_curv_r[rs_r]) begin
            tm_re    = 1'b1;
            tm_raddr = th_addr(rs_r, cur_rs);
          end else begin
            task_curv_nxt[rs_r] = 1'b1;
            task_cur_nxt[rs_r]  = '0;
            tm_we    = 1'b1;
            tm_waddr = th_addr(rs_r, '0);
            tm_wdata = slice_r;
          end
        end else if (count_r != '0) begin
          run_v_nxt = 1'b1;
          rs_nxt    = order_r[0];
          task_curv_nxt[order_r[0]] = 1'b1;
          task_cur_nxt[order_r[0]]  = '0;
          tm_we    = 1'b1;
          tm_waddr = th_addr(order_r[0], '0);
          tm_wdata = slice_r;
        end
      end
      ST_TICK_DEC: begin
        tm_we    = 1'b1;
        tm_waddr = th_addr(rs_r, cur_rs);
        if (dec == 8'd0) begin
          tm_wdata = slice_r;
          if (next_ok) begin
            task_cur_nxt[rs_r] = c1[THR_W-1:0];
          end else begin
            task_cur_nxt[rs_r] = '0;
            k_nxt = '0;
          end
        end else begin
          tm_wdata = dec;
        end
      end
      ST_ADV: begin
        if (k_end) begin
          run_v_nxt = 1'b0;
        end else if (cs == rs_r) begin
          if (k_r + (TASK_W+1)'(1) < count_r) begin
            rs_nxt = order_r[TASK_W'(k_r + (TASK_W+1)'(1))];
          end else begin
            run_v_nxt = 1'b0;
          end
        end else begin
          k_nxt = k_r + (TASK_W+1)'(1);
        end
      end
      ST_RESP_RD: begin
        id_re    = 1'b1;
        id_raddr = th_addr(rs_r, cur_rs);
      end
      ST_OUT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_new_id_nxt = id_r;
          out_rv_nxt     = run_v_r;
          out_rpid_nxt   = run_v_r ? task_pid_r[rs_r] : '0;
          out_rpv_nxt    = run_v_r && task_hp_r[rs_r];
          out_rppid_nxt  = (run_v_r && task_hp_r[rs_r]) ? task_par_r[rs_r] : '0;
          out_rtid_nxt   = (run_v_r && task_curv_r[rs_r]) ? id_q : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      task_valid_r <= '0;
      task_dead_r  <= '0;
      task_curv_r  <= '0;
      count_r      <= '0;
      thr_valid_r  <= '0;
      thr_dead_r   <= '0;
      run_v_r      <= 1'b0;
      rs_r         <= '0;
      cleanup_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      task_valid_r <= task_valid_nxt;
      task_dead_r  <= task_dead_nxt;
      task_curv_r  <= task_curv_nxt;
      count_r      <= count_nxt;
      thr_valid_r  <= thr_valid_nxt;
      thr_dead_r   <= thr_dead_nxt;
      run_v_r      <= run_v_nxt;
      rs_r         <= rs_nxt;
      cleanup_r    <= cleanup_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    tgt_r        <= tgt_nxt;
    task_pid_r   <= task_pid_nxt;
    task_hp_r    <= task_hp_nxt;
    task_par_r   <= task_par_nxt;
    task_cur_r   <= task_cur_nxt;
    order_r      <= order_nxt;
    k_r          <= k_nxt;
    n_r          <= n_nxt;
    adv_r        <= adv_nxt;
    p_r          <= p_nxt;
    kept_r       <= kept_nxt;
    newcur_r     <= newcur_nxt;
    lost_r       <= lost_nxt;
    status_r     <= status_nxt;
    id_r         <= id_nxt;
    out_status_r <= out_status_nxt;
    out_new_id_r <= out_new_id_nxt;
    out_rv_r     <= out_rv_nxt;
    out_rpid_r   <= out_rpid_nxt;
    out_rpv_r    <= out_rpv_nxt;
    out_rppid_r  <= out_rppid_nxt;
    out_rtid_r   <= out_rtid_nxt;
  end

  trr_ram #(.DW(8), .DEPTH(NTH), .AW(TH_AW)) u_ident_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .re    (id_re),
    .raddr (id_raddr),
    .rdata (id_q)
  );

  trr_ram #(.DW(8), .DEPTH(NTH), .AW(TH_AW)) u_time_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (tm_waddr),
    .wdata (tm_wdata),
    .re    (tm_re),
    .raddr (tm_raddr),
    .rdata (tm_q)
  );

  assign out_valid                = out_valid_r;
  assign out_status               = out_status_r;
  assign out_new_id               = out_new_id_r;
  assign out_running_valid        = out_rv_r;
  assign out_running_pid          = out_rpid_r;
  assign out_running_parent_valid = out_rpv_r;
  assign out_running_parent_pid   = out_rppid_r;
  assign out_running_thread_id    = out_rtid_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (TASK_W+1)'(MAX_TASKS))
    else $error("task count beyond table size");

  a_running_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && run_v_r) |-> task_valid_r[rs_r])
    else $error("running slot holds no task");

  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(task_valid_r) == int'(count_r)))
    else $error("task count disagrees with valid slots");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_DISPATCH))
    else $error("accepted beat not dispatched");

endmodule

FILE: verif/tb_two_level_round_robin_scheduler.sv
// Testbench for the two-level round-robin scheduler: directed table, then random requests.
`timescale 1ns / 100ps
module tb_two_level_round_robin_scheduler;
  import trr_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic       status;
    logic [7:0] new_id;
    logic       rv;
    logic [2:0] rpid;
    logic       rpv;
    logic [2:0] rppid;
    logic [7:0] rtid;
  } sched_resp_t;

  typedef struct {
    kind_t       kind;
    logic [2:0]  pid;
    bit          typed;
    sched_resp_t resp;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = '0;
  logic [2:0] in_target_pid = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status;
  logic [7:0] out_new_id;
  logic out_running_valid;
  logic [2:0] out_running_pid;
  logic out_running_parent_valid;
  logic [2:0] out_running_parent_pid;
  logic [7:0] out_running_thread_id;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  two_level_round_robin_scheduler uut (.*);

  always #5 clk = ~clk;

  // predictor state
  bit         m_en;
  logic [7:0] m_slice;
  bit         t_valid[MAX_TASKS];
  logic [2:0] t_pid[MAX_TASKS];
  bit         t_haspar[MAX_TASKS];
  logic [2:0] t_par[MAX_TASKS];
  bit         t_dead[MAX_TASKS];
  int         t_order[MAX_TASKS];
  int         t_count;
  bit         th_valid[NTH];
  logic [7:0] th_ident[NTH];
  bit         th_dead[NTH];
  logic [7:0] th_left[NTH];
  bit         cur_v[MAX_TASKS];
  int         cur[MAX_TASKS];
  bit         run_v;
  int         run_s;
  bit         clean_pend;

  sched_resp_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit idle_free = 1'b0;
  bit hold_off = 1'b0;

  function automatic int ti(int s, int p);
    return s * MAX_THREADS + p;
  endfunction

  task automatic sched_reset();
    m_en = 1;
    m_slice = SLICE_RESET;
    t_count = 0;
    run_v = 0;
    run_s = 0;
    clean_pend = 0;
    for (int s = 0; s < MAX_TASKS; s++) begin
      t_valid[s] = 0; t_pid[s] = 0; t_haspar[s] = 0; t_par[s] = 0;
      t_dead[s] = 0; t_order[s] = 0; cur_v[s] = 0; cur[s] = 0;
    end
    for (int i = 0; i < NTH; i++) begin
      th_valid[i] = 0; th_ident[i] = 0; th_dead[i] = 0; th_left[i] = 0;
    end
  endtask

  function automatic void compact_threads(int s);
    int kept, newcur, c;
    bit cv, lost;
    kept = 0; newcur = 0; c = cur[s]; cv = cur_v[s]; lost = 0;
    if (th_dead[ti(s, 0)]) begin
      t_dead[s] = 1;
      return;
    end
    for (int p = 0; p < MAX_THREADS; p++) begin
      if (!th_valid[ti(s, p)]) break;
      if (cv && p == c) begin
        newcur = kept;
        lost = th_dead[ti(s, p)];
      end
      if (!th_dead[ti(s, p)]) begin
        th_valid[ti(s, kept)] = 1;
        th_ident[ti(s, kept)] = th_ident[ti(s, p)];
        th_dead[ti(s, kept)] = 0;
        th_left[ti(s, kept)] = th_left[ti(s, p)];
        kept++;
      end
    end
    for (int p = kept; p < MAX_THREADS; p++) begin
      th_valid[ti(s, p)] = 0;
      th_dead[ti(s, p)] = 0;
    end
    if (cv) begin
      if (newcur >= kept) newcur = 0;
      cur[s] = newcur;
      if (lost) th_left[ti(s, newcur)] = m_slice;
    end
  endfunction

  function automatic void reap_dead();
    int n;
    bit adv;
    n = 0; adv = 0;
    for (int k = 0; k < t_count; k++) compact_threads(t_order[k]);
    for (int k = 0; k < t_count; k++) begin
      int s;
      s = t_order[k];
      if (t_dead[s]) begin
        if (run_v && run_s == s) adv = 1;
        t_valid[s] = 0; t_dead[s] = 0; cur_v[s] = 0;
        for (int p = 0; p < MAX_THREADS; p++) begin
          th_valid[ti(s, p)] = 0;
          th_dead[ti(s, p)] = 0;
        end
      end else begin
        t_order[n++] = s;
        if (adv) begin
          run_s = s;
          adv = 0;
        end
      end
    end
    if (adv) run_v = 0;
    t_count = n;
  endfunction

  function automatic void next_task();
    for (int k = 0; k < t_count; k++) begin
      if (t_order[k] == run_s) begin
        if (k + 1 < t_count) run_s = t_order[k + 1];
        else run_v = 0;
        return;
      end
    end
    run_v = 0;
  endfunction

  function automatic void select_main(int s);
    cur_v[s] = 1;
    cur[s] = 0;
    th_left[ti(s, 0)] = m_slice;
  endfunction

  function automatic void sched_tick();
    if (!m_en) return;
    if (clean_pend) begin
      reap_dead();
      clean_pend = 0;
    end
    if (run_v) begin
      int s, c;
      s = run_s;
      if (cur_v[s]) begin
        c = cur[s];
        th_left[ti(s, c)] = th_left[ti(s, c)] - 8'd1;
        if (th_left[ti(s, c)] == 0) begin
          th_left[ti(s, c)] = m_slice;
          if (c + 1 < MAX_THREADS && th_valid[ti(s, c + 1)]) cur[s] = c + 1;
          else begin
            cur[s] = 0;
            next_task();
          end
        end
      end else select_main(s);
    end else if (t_count > 0) begin
      run_v = 1;
      run_s = t_order[0];
      select_main(run_s);
    end
  endfunction

  function automatic sched_resp_t sched_step(kind_t kind, logic [2:0] tgt);
    sched_resp_t r;
    r = '0;
    case (kind)
      KIND_TICK: sched_tick();
      KIND_SPAWN: begin
        int s, p;
        for (s = 0; s < MAX_TASKS; s++) if (!t_valid[s]) break;
        if (s >= MAX_TASKS) r.status = 1;
        else begin
          for (p = 0; p < MAX_TASKS; p++) begin
            bit used;
            used = 0;
            for (int k = 0; k < MAX_TASKS; k++)
              if (t_valid[k] && t_pid[k] == p) used = 1;
            if (!used) break;
          end
          t_valid[s] = 1; t_pid[s] = 3'(p); t_haspar[s] = run_v;
          t_par[s] = run_v ? t_pid[run_s] : 3'd0;
          t_dead[s] = 0; cur_v[s] = 0; cur[s] = 0;
          for (int k = 0; k < MAX_THREADS; k++) begin
            th_valid[ti(s, k)] = 0;
            th_dead[ti(s, k)] = 0;
          end
          th_valid[ti(s, 0)] = 1; th_ident[ti(s, 0)] = 0; th_left[ti(s, 0)] = m_slice;
          t_order[t_count++] = s;
          r.new_id = 8'(p);
        end
      end
      KIND_ADD: begin
        int s, n, nid;
        n = 0;
        if (!run_v) r.status = 1;
        else begin
          s = run_s;
          while (n < MAX_THREADS && th_valid[ti(s, n)]) n++;
          if (n == 0 || n >= MAX_THREADS) r.status = 1;
          else begin
            nid = th_ident[ti(s, n - 1)] + 1;
            if (nid >= 255) r.status = 1;
            else begin
              th_valid[ti(s, n)] = 1; th_ident[ti(s, n)] = 8'(nid);
              th_dead[ti(s, n)] = 0; th_left[ti(s, n)] = m_slice;
              r.new_id = 8'(nid);
            end
          end
        end
      end
      KIND_FIN: begin
        if (run_v && cur_v[run_s]) begin
          th_dead[ti(run_s, cur[run_s])] = 1;
          clean_pend = 1;
        end else r.status = 1;
      end
      KIND_KILL: begin
        r.status = 1;
        for (int k = 0; k < t_count; k++) begin
          if (t_pid[t_order[k]] == tgt) begin
            t_dead[t_order[k]] = 1;
            clean_pend = 1;
            r.status = 0;
            sched_tick();
            break;
          end
        end
      end
      default: r.status = 1;
    endcase
    r.rv = run_v;
    if (run_v) begin
      r.rpid = t_pid[run_s];
      r.rpv = t_haspar[run_s];
      r.rppid = t_haspar[run_s] ? t_par[run_s] : 3'd0;
      if (cur_v[run_s]) r.rtid = th_ident[ti(run_s, cur[run_s])];
    end
    return r;
  endfunction

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  task automatic send(logic [2:0] kind, logic [2:0] pid);
    @(posedge clk);
    while (!idle_free && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_target_pid <= pid;
    expected_q.push_back(sched_step(kind_t'(kind), pid));
    do @(posedge clk); while (in_stall);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_ENABLE) m_en = data[0];
    else m_slice = data;
  endtask

  // check results
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result beat");
        errors++;
      end else begin
        sched_resp_t w;
        w = expected_q.pop_front();
        if (out_status !== w.status) report("status", out_status, w.status);
        if (out_new_id !== w.new_id) report("new_id", out_new_id, w.new_id);
        if (out_running_valid !== w.rv) report("running_valid", out_running_valid, w.rv);
        if (out_running_pid !== w.rpid) report("running_pid", out_running_pid, w.rpid);
        if (out_running_parent_valid !== w.rpv)
          report("running_parent_valid", out_running_parent_valid, w.rpv);
        if (out_running_parent_pid !== w.rppid)
          report("running_parent_pid", out_running_parent_pid, w.rppid);
        if (out_running_thread_id !== w.rtid)
          report("running_thread_id", out_running_thread_id, w.rtid);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= hold_off || (!idle_free && $urandom_range(99) < 11);
  end

  // long hold-off of the receiver
  initial begin
    wait (rst_n);
    repeat (3000) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("two_level_round_robin_scheduler regression: fail");
      $finish;
    end
  end

  stim_row_t directed[$];

  function automatic stim_row_t row(kind_t k, logic [2:0] p, bit typed,
                                   sched_resp_t r = '0);
    stim_row_t x;
    x.kind = k; x.pid = p; x.typed = typed; x.resp = r;
    return x;
  endfunction

  initial begin
    sched_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // after reset: a tick and refusals with nothing running
    directed.push_back(row(KIND_TICK, 3'd0, 1, '0));
    directed.push_back(row(KIND_ADD, 3'd0, 1, sched_resp_t'({1'b1, 24'd0})));
    directed.push_back(row(KIND_FIN, 3'd0, 1, sched_resp_t'({1'b1, 24'd0})));
    directed.push_back(row(KIND_KILL, 3'd7, 1, sched_resp_t'({1'b1, 24'd0})));
    directed.push_back(row(kind_t'(3'd5), 3'd0, 1, sched_resp_t'({1'b1, 24'd0})));
    directed.push_back(row(kind_t'(3'd7), 3'd7, 1, sched_resp_t'({1'b1, 24'd0})));
    for (int i = 0; i < 9; i++) directed.push_back(row(KIND_SPAWN, 3'd0, 0));
    directed.push_back(row(KIND_TICK, 3'd0, 0));
    for (int i = 0; i < 4; i++) directed.push_back(row(KIND_ADD, 3'd0, 0));
    directed.push_back(row(KIND_FIN, 3'd0, 0));
    directed.push_back(row(KIND_TICK, 3'd0, 0));
    directed.push_back(row(KIND_KILL, 3'd0, 0));
    directed.push_back(row(KIND_KILL, 3'd7, 0));
    directed.push_back(row(KIND_SPAWN, 3'd0, 0));
    foreach (directed[i]) begin
      send(directed[i].kind, directed[i].pid);
      if (directed[i].typed) expected_q[expected_q.size() - 1] = directed[i].resp;
    end
    drain();
    // random phases over slice and enable settings
    for (int ph = 0; ph < 6; ph++) begin
      logic [7:0] sl;
      case (ph)
        0: sl = 8'd1;
        1: sl = 8'd255;
        2: sl = 8'd0;
        default: sl = 8'($urandom_range(1, 6));
      endcase
      write_cfg(CFG_SLICE, sl);
      write_cfg(CFG_ENABLE, (ph == 4) ? 8'd0 : 8'd1);
      idle_free = (ph == 3);
      for (int n = 0; n < 310; n++) begin
        int r;
        logic [2:0] k;
        r = $urandom_range(99);
        if (r < 45) k = KIND_TICK;
        else if (r < 60) k = KIND_SPAWN;
        else if (r < 72) k = KIND_ADD;
        else if (r < 84) k = KIND_FIN;
        else if (r < 97) k = KIND_KILL;
        else k = 3'($urandom_range(5, 7));
        send(k, 3'($urandom_range(7)));
      end
      drain();
    end
    write_cfg(CFG_ENABLE, 8'd1);
    drain();
    if (errors == 0) begin
      $display("two_level_round_robin_scheduler regression: pass");
    end else begin
      $display("two_level_round_robin_scheduler regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/trr_pkg.sv
rtl/trr_ram.sv
rtl/two_level_round_robin_scheduler.sv
verif/tb_two_level_round_robin_scheduler.sv
